// File: design/line_plane_intersection_macros.svh
// Assertion macros for the line and plane intersection block.
// Included by the modules that check their own logic; relies on clk and rst_n in scope.
`ifndef LINE_PLANE_INTERSECTION_MACROS_SVH
`define LINE_PLANE_INTERSECTION_MACROS_SVH
`ifndef SYNTH
`define LPI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpi check failed");
`define LPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpi check failed");
`else
`define LPI_ASSERT_NOW(lbl, ante, cons)
`define LPI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: design/lpi_pkg.sv
// Constants and types of the line and plane intersection pipeline.
// No dependencies; used by the channel interfaces, the divider stage and the top level.
package lpi_pkg;

  localparam int CB    = 20;              // coordinate width, Q11.8
  localparam int CW3   = 3 * CB;          // packed plane point
  localparam int SUBW  = CB + 1;          // coordinate difference
  localparam int PRW   = 2 * SUBW;        // cross product term
  localparam int NW    = PRW + 1;         // normal component
  localparam int LOW   = 22;              // split width for wide products
  localparam int HIW   = NW - LOW;
  localparam int NTW   = NW + SUBW;       // n * (a - s)
  localparam int NUMW  = NTW + 2;
  localparam int DHW   = NW + HIW;
  localparam int DLW   = NW + LOW + 1;
  localparam int DENHW = DHW + 2;
  localparam int DENLW = DLW + 2;
  localparam int DENW  = 2 * NW + 4;
  localparam int ANW   = 3 * LOW;         // |num|, three chunks
  localparam int DMW   = 2 * LOW;         // |d| padded, two chunks
  localparam int PPW   = 2 * LOW;
  localparam int PW    = ANW + DMW;
  localparam int QW    = 41;              // quotient bits below the clamp point
  localparam int DW    = DENW + QW + 1;
  localparam int OFFW  = QW + 1;
  localparam int HW    = QW + 2;
  localparam int CMAX  = 2 ** (CB - 1) - 1;
  localparam int CMIN  = -(2 ** (CB - 1));
  localparam logic [OFFW-1:0] OFF_LIM = OFFW'(1) << (QW - 1);

  localparam int DIV0  = 10;              // stage index of the first quotient bit
  localparam int NSTG  = DIV0 + QW + 2;

  localparam logic [1:0] REG_A = 2'd0;
  localparam logic [1:0] REG_B = 2'd1;
  localparam logic [1:0] REG_C = 2'd2;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t hit_x;
    coord_t hit_y;
    coord_t hit_z;
    logic   parallel;
    logic   saturated;
  } rsp_t;

  typedef struct packed {
    logic [2:0][DW-1:0] rem;
    logic [2:0][QW-1:0] q;
    logic [DENW-1:0]    aden;
    logic [2:0][CB-1:0] s;
    logic [2:0]         neg;
    logic [2:0]         ovf;
    logic               par;
  } div_t;

endpackage

// File: design/lpi_if.sv
// Request and result channels of the line and plane intersection block.
// Depends on lpi_pkg for the coordinate type.
interface lpi_req_if;
  import lpi_pkg::*;
  logic   valid;
  logic   ready;
  logic   req_type;
  coord_t start_x;
  coord_t start_y;
  coord_t start_z;
  coord_t dir_x;
  coord_t dir_y;
  coord_t dir_z;
  modport source(output valid, req_type, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                 input ready);
  modport sink(input valid, req_type, start_x, start_y, start_z, dir_x, dir_y, dir_z,
               output ready);
endinterface

interface lpi_rsp_if;
  import lpi_pkg::*;
  logic   valid;
  logic   ready;
  coord_t hit_x;
  coord_t hit_y;
  coord_t hit_z;
  logic   parallel;
  logic   saturated;
  modport source(output valid, hit_x, hit_y, hit_z, parallel, saturated, input ready);
  modport sink(input valid, hit_x, hit_y, hit_z, parallel, saturated, output ready);
endinterface

// File: design/line_plane_intersection.sv
// Line and plane intersection, top level: plane registers, normal, dot products,
// magnitude products and rounding; uses lpi_pkg, lpi_if and lpi_div_stage.
//
//  port      dir  carries
//  cfg_*     in   plane point writes (index 0..2 = a, b, c)
//  in_req    in   req_type, start, dir
//  out_rsp   out  hit point, parallel, saturated
//
// One request per cycle while the output buffer is not full.
// The divider is a 41-stage restoring divider, one quotient bit per stage.
// Sync reset clears valid bits, plane points, 2-entry buffer count and pointers.
// The pipeline stalls as a whole only when the output buffer holds two results.
`include "line_plane_intersection_macros.svh"
module line_plane_intersection (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_idx,
  input  logic [lpi_pkg::CW3-1:0]  cfg_data,
  lpi_req_if.sink                  in_req,
  lpi_rsp_if.source                out_rsp
);
  import lpi_pkg::*;

  logic [CW3-1:0] pa_r, pb_r, pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_r <= '0;
      pb_r <= '0;
      pc_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_A:   pa_r <= cfg_data;
        REG_B:   pb_r <= cfg_data;
        REG_C:   pc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // plane normal, three stages behind the plane registers
  coord_t                 ca [3];
  coord_t                 cbp[3];
  coord_t                 ccp[3];
  logic signed [SUBW-1:0] cu_r[3], cv_r[3];
  logic signed [PRW-1:0]  cp_r[6];
  logic signed [NW-1:0]   nrm_r[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ca[i]  = $signed(pa_r[i*CB +: CB]);
      cbp[i] = $signed(pb_r[i*CB +: CB]);
      ccp[i] = $signed(pc_r[i*CB +: CB]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      cu_r[i] <= SUBW'(cbp[i]) - SUBW'(ca[i]);
      cv_r[i] <= SUBW'(ccp[i]) - SUBW'(ca[i]);
    end
    cp_r[0] <= cu_r[1] * cv_r[2];
    cp_r[1] <= cu_r[2] * cv_r[1];
    cp_r[2] <= cu_r[2] * cv_r[0];
    cp_r[3] <= cu_r[0] * cv_r[2];
    cp_r[4] <= cu_r[0] * cv_r[1];
    cp_r[5] <= cu_r[1] * cv_r[0];
    nrm_r[0] <= NW'(cp_r[0]) - NW'(cp_r[1]);
    nrm_r[1] <= NW'(cp_r[2]) - NW'(cp_r[3]);
    nrm_r[2] <= NW'(cp_r[4]) - NW'(cp_r[5]);
  end

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic [1:0]      cnt_r;
  logic            en, push, pop;

  assign en           = (cnt_r != 2'd2);
  assign in_req.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_req.valid};
    end
  end

  // stages 1 to 3: request, a - s, alignment with the normal
  logic   s1_mode_r, s2_mode_r, s3_mode_r;
  coord_t s1_s_r[3], s2_s_r[3], s3_s_r[3];
  coord_t s1_d_r[3], s2_d_r[3], s3_d_r[3];
  logic signed [SUBW-1:0] s2_as_r[3], s3_as_r[3];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode_r <= in_req.req_type;
      s1_s_r[0] <= in_req.start_x;
      s1_s_r[1] <= in_req.start_y;
      s1_s_r[2] <= in_req.start_z;
      s1_d_r[0] <= in_req.dir_x;
      s1_d_r[1] <= in_req.dir_y;
      s1_d_r[2] <= in_req.dir_z;
      s2_mode_r <= s1_mode_r;
      s3_mode_r <= s2_mode_r;
      for (int i = 0; i < 3; i++) begin
        s2_s_r[i]  <= s1_s_r[i];
        s2_d_r[i]  <= s1_d_r[i];
        s2_as_r[i] <= SUBW'(ca[i]) - SUBW'(s1_s_r[i]);
        s3_s_r[i]  <= s2_s_r[i];
        s3_d_r[i]  <= s2_d_r[i];
        s3_as_r[i] <= s2_as_r[i];
      end
    end
  end

  // stage 4: direction select and dot product terms
  logic signed [NW-1:0]  dsel[3];
  logic signed [NW-1:0]  s4_d_r[3];
  logic signed [NTW-1:0] s4_nt_r[3];
  logic signed [DHW-1:0] s4_dh_r[3];
  logic signed [DLW-1:0] s4_dl_r[3];
  coord_t                s4_s_r[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsel[i] = s3_mode_r ? nrm_r[i] : NW'(s3_d_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_d_r[i]  <= dsel[i];
        s4_s_r[i]  <= s3_s_r[i];
        s4_nt_r[i] <= nrm_r[i] * s3_as_r[i];
        s4_dh_r[i] <= nrm_r[i] * $signed(dsel[i][NW-1:LOW]);
        s4_dl_r[i] <= nrm_r[i] * $signed({1'b0, dsel[i][LOW-1:0]});
      end
    end
  end

  // stages 5 and 6: sums
  logic signed [NUMW-1:0]  s5_num_r, s6_num_r;
  logic signed [DENHW-1:0] s5_dh_r;
  logic signed [DENLW-1:0] s5_dl_r;
  logic signed [DENW-1:0]  s6_den_r;
  logic signed [NW-1:0]    s5_d_r[3], s6_d_r[3];
  coord_t                  s5_s_r[3], s6_s_r[3];

  always_ff @(posedge clk) begin
    if (en) begin
      s5_num_r <= NUMW'(s4_nt_r[0]) + NUMW'(s4_nt_r[1]) + NUMW'(s4_nt_r[2]);
      s5_dh_r  <= DENHW'(s4_dh_r[0]) + DENHW'(s4_dh_r[1]) + DENHW'(s4_dh_r[2]);
      s5_dl_r  <= DENLW'(s4_dl_r[0]) + DENLW'(s4_dl_r[1]) + DENLW'(s4_dl_r[2]);
      s6_num_r <= s5_num_r;
      s6_den_r <= (DENW'(s5_dh_r) <<< LOW) + DENW'(s5_dl_r);
      for (int i = 0; i < 3; i++) begin
        s5_d_r[i] <= s4_d_r[i];
        s5_s_r[i] <= s4_s_r[i];
        s6_d_r[i] <= s5_d_r[i];
        s6_s_r[i] <= s5_s_r[i];
      end
    end
  end

  // stage 7: magnitudes and result signs
  logic [ANW-1:0]  s7_an_r;
  logic [DENW-1:0] s7_ad_r, s8_ad_r, s9_ad_r;
  logic [NW-1:0]   s7_dm_r[3];
  logic [2:0]      s7_neg_r, s8_neg_r, s9_neg_r;
  logic            s7_par_r, s8_par_r, s9_par_r;
  coord_t          s7_s_r[3], s8_s_r[3], s9_s_r[3];
  logic            nneg, dneg;

  assign nneg = s6_num_r[NUMW-1];
  assign dneg = s6_den_r[DENW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      s7_an_r  <= ANW'(nneg ? -s6_num_r : s6_num_r);
      s7_ad_r  <= dneg ? DENW'(-s6_den_r) : DENW'(s6_den_r);
      s7_par_r <= (s6_den_r == '0);
      for (int i = 0; i < 3; i++) begin
        s7_dm_r[i]  <= s6_d_r[i][NW-1] ? NW'(-s6_d_r[i]) : NW'(s6_d_r[i]);
        s7_neg_r[i] <= nneg ^ s6_d_r[i][NW-1] ^ dneg;
        s7_s_r[i]   <= s6_s_r[i];
      end
    end
  end

  // stages 8 and 9: |num| * |d| as partial products, then their sum
  logic [PPW-1:0] s8_pp_r[3][3][2];
  logic [DMW-1:0] dmx[3];
  logic [PW-1:0]  psum[3];
  logic [PW-1:0]  s9_prod_r[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmx[i]  = DMW'(s7_dm_r[i]);
      psum[i] = '0;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 2; b++) begin
          psum[i] = psum[i] + (PW'(s8_pp_r[i][a][b]) << (LOW * (a + b)));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int a = 0; a < 3; a++) begin
          for (int b = 0; b < 2; b++) begin
            s8_pp_r[i][a][b] <= PPW'(s7_an_r[a*LOW +: LOW]) * PPW'(dmx[i][b*LOW +: LOW]);
          end
        end
        s8_s_r[i]    <= s7_s_r[i];
        s9_s_r[i]    <= s8_s_r[i];
        s9_prod_r[i] <= psum[i];
      end
      s8_ad_r  <= s7_ad_r;
      s9_ad_r  <= s8_ad_r;
      s8_neg_r <= s7_neg_r;
      s9_neg_r <= s8_neg_r;
      s8_par_r <= s7_par_r;
      s9_par_r <= s8_par_r;
    end
  end

  // stage 10: clamp test, then one quotient bit per stage
  div_t          s10_r;
  div_t          dv[QW+1];
  logic [DW-1:0] lim;

  assign lim = DW'(s9_ad_r) << QW;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s10_r.rem[i] <= DW'(s9_prod_r[i]);
        s10_r.q[i]   <= '0;
        s10_r.s[i]   <= s9_s_r[i];
        s10_r.ovf[i] <= (DW'(s9_prod_r[i]) >= lim);
      end
      s10_r.aden <= s9_ad_r;
      s10_r.neg  <= s9_neg_r;
      s10_r.par  <= s9_par_r;
    end
  end

  assign dv[0] = s10_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    lpi_div_stage u_stage (
      .clk     (clk),
      .en      (en),
      .bit_idx (6'(QW - 1 - k)),
      .d_i     (dv[k]),
      .d_o     (dv[k+1])
    );
  end

  // rounding to nearest, ties away from zero; offset clamp
  div_t                   dq;
  logic [2:0]             up;
  logic [OFFW-1:0]        qr[3], mag[3];
  logic signed [OFFW-1:0] r1_off_r[3];
  coord_t                 r1_s_r[3];
  logic                   r1_par_r;

  assign dq = dv[QW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up[i]  = ({dq.rem[i][DENW-1:0], 1'b0} >= {1'b0, dq.aden});
      qr[i]  = {1'b0, dq.q[i]} + OFFW'(up[i]);
      mag[i] = (dq.ovf[i] || qr[i] > OFF_LIM) ? OFF_LIM : qr[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r1_off_r[i] <= dq.neg[i] ? -$signed(mag[i]) : $signed(mag[i]);
        r1_s_r[i]   <= $signed(dq.s[i]);
      end
      r1_par_r <= dq.par;
    end
  end

  // final add and saturation
  logic signed [HW-1:0] h[3];
  coord_t               hc[3];
  logic [2:0]           hs;
  rsp_t                 r2_nxt, r2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h[i] = HW'(r1_s_r[i]) + HW'(r1_off_r[i]);
      if (h[i] > HW'(CMAX)) begin
        hc[i] = CB'(CMAX);
        hs[i] = 1'b1;
      end else if (h[i] < HW'(CMIN)) begin
        hc[i] = CB'(CMIN);
        hs[i] = 1'b1;
      end else begin
        hc[i] = h[i][CB-1:0];
        hs[i] = 1'b0;
      end
    end
    if (r1_par_r) begin
      r2_nxt.hit_x     = r1_s_r[0];
      r2_nxt.hit_y     = r1_s_r[1];
      r2_nxt.hit_z     = r1_s_r[2];
      r2_nxt.parallel  = 1'b1;
      r2_nxt.saturated = 1'b0;
    end else begin
      r2_nxt.hit_x     = hc[0];
      r2_nxt.hit_y     = hc[1];
      r2_nxt.hit_z     = hc[2];
      r2_nxt.parallel  = 1'b0;
      r2_nxt.saturated = |hs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r <= r2_nxt;
    end
  end

  // two-entry output buffer
  rsp_t       fifo_r[2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_nxt;

  assign push    = en && vld_r[NSTG-1];
  assign pop     = out_rsp.valid && out_rsp.ready;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_r] <= r2_r;
    end
  end

  assign out_rsp.valid     = (cnt_r != 2'd0);
  assign out_rsp.hit_x     = fifo_r[rd_r].hit_x;
  assign out_rsp.hit_y     = fifo_r[rd_r].hit_y;
  assign out_rsp.hit_z     = fifo_r[rd_r].hit_z;
  assign out_rsp.parallel  = fifo_r[rd_r].parallel;
  assign out_rsp.saturated = fifo_r[rd_r].saturated;

  `LPI_ASSERT_NOW(a_cnt_max, 1'b1, cnt_r != 2'd3)
  `LPI_ASSERT_NEXT(a_stall_hold, !en && vld_r[NSTG-1], vld_r[NSTG-1])
  `LPI_ASSERT_NEXT(a_full_block, cnt_r == 2'd2 && !pop, !push)
  `LPI_ASSERT_NOW(a_par_nosat, out_rsp.valid && out_rsp.parallel, !out_rsp.saturated)

endmodule

// File: design/lpi_div_stage.sv
// One restoring division step for all three axes: one quotient bit per stage.
// Depends on lpi_pkg (div_t).
module lpi_div_stage (
  input  logic         clk,
  input  logic         en,
  input  logic [5:0]   bit_idx,
  input  lpi_pkg::div_t d_i,
  output lpi_pkg::div_t d_o
);
  import lpi_pkg::*;

  div_t          d_r;
  div_t          d_nxt;
  logic [DW-1:0] sh;

  always_comb begin
    d_nxt = d_i;
    sh    = DW'(d_i.aden) << bit_idx;
    for (int i = 0; i < 3; i++) begin
      if (d_i.rem[i] >= sh) begin
        d_nxt.rem[i]        = d_i.rem[i] - sh;
        d_nxt.q[i][bit_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

// File: dv/tb_line_plane_intersection.sv
// Testbench for line_plane_intersection: directed and random requests against a
// self-contained predictor of the hit point. Uses lpi_pkg and the lpi_if channels.
`timescale 1ns / 1ps
module tb_line_plane_intersection;
  import lpi_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int LATENCY = 60;
  localparam int WDOG_LIMIT = 3000;
  localparam longint OFF_CAP = longint'(1) << 40;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [CW3-1:0] cfg_data;

  lpi_req_if req_if ();
  lpi_rsp_if rsp_if ();

  line_plane_intersection uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_req(req_if.sink), .out_rsp(rsp_if.source)
  );

  logic [CW3-1:0] plane_a, plane_b, plane_c;
  rsp_t expected_hits[$];
  int errors = 0;
  int n_req = 0, n_par = 0, n_sat = 0, n_rsp = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int rx_cyc = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [CW3-1:0] pack_pt(int x, int y, int z);
    return {coord_t'(z), coord_t'(y), coord_t'(x)};
  endfunction

  function automatic rsp_t predict_hit(logic typ, coord_t sx, coord_t sy, coord_t sz,
                                       coord_t dx, coord_t dy, coord_t dz);
    longint a[3], b[3], c[3], s[3], d[3], u[3], v[3], n[3], hv[3];
    logic signed [159:0] num, den, ni, ti;
    logic [159:0] anum, aden, prod, q, r;
    longint off, dm;
    logic sat, neg;
    rsp_t res;
    s = '{longint'(sx), longint'(sy), longint'(sz)};
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'(coord_t'(plane_a[i*CB +: CB]));
      b[i] = longint'(coord_t'(plane_b[i*CB +: CB]));
      c[i] = longint'(coord_t'(plane_c[i*CB +: CB]));
      u[i] = b[i] - a[i];
      v[i] = c[i] - a[i];
    end
    n[0] = u[1] * v[2] - u[2] * v[1];
    n[1] = u[2] * v[0] - u[0] * v[2];
    n[2] = u[0] * v[1] - u[1] * v[0];
    if (typ) d = n;
    else d = '{longint'(dx), longint'(dy), longint'(dz)};
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      ni = n[i];
      ti = a[i] - s[i];
      num += ni * ti;
      ti = d[i];
      den += ni * ti;
    end
    sat = 0;
    if (den == 0) begin
      hv = s;
    end else begin
      anum = (num < 0) ? -num : num;
      aden = (den < 0) ? -den : den;
      for (int i = 0; i < 3; i++) begin
        dm = (d[i] < 0) ? -d[i] : d[i];
        prod = anum * 160'(dm);
        q = prod / aden;
        r = prod % aden;
        if ((r << 1) >= aden) q = q + 1;
        off = (q > 160'(OFF_CAP)) ? OFF_CAP : longint'(q);
        neg = ((num < 0) != (d[i] < 0)) != (den < 0);
        if (neg) off = -off;
        hv[i] = s[i] + off;
        if (hv[i] > CMAX) begin hv[i] = CMAX; sat = 1; end
        if (hv[i] < CMIN) begin hv[i] = CMIN; sat = 1; end
      end
    end
    res.hit_x = coord_t'(hv[0]);
    res.hit_y = coord_t'(hv[1]);
    res.hit_z = coord_t'(hv[2]);
    res.parallel = (den == 0);
    res.saturated = sat;
    return res;
  endfunction

  // request monitor: predict on acceptance
  always @(posedge clk) begin
    if (rst_n && req_if.valid && req_if.ready) begin
      expected_hits.push_back(predict_hit(req_if.req_type, req_if.start_x, req_if.start_y,
                                          req_if.start_z, req_if.dir_x, req_if.dir_y,
                                          req_if.dir_z));
      n_req++;
    end
  end

  // result checker
  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      n_rsp++;
      if (expected_hits.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = expected_hits.pop_front();
        if (e.parallel) n_par++;
        if (e.saturated) n_sat++;
        if (rsp_if.hit_x !== e.hit_x) begin
          $error("hit_x exp %0d got %0d", e.hit_x, rsp_if.hit_x); errors++;
        end
        if (rsp_if.hit_y !== e.hit_y) begin
          $error("hit_y exp %0d got %0d", e.hit_y, rsp_if.hit_y); errors++;
        end
        if (rsp_if.hit_z !== e.hit_z) begin
          $error("hit_z exp %0d got %0d", e.hit_z, rsp_if.hit_z); errors++;
        end
        if (rsp_if.parallel !== e.parallel) begin
          $error("parallel exp %0b got %0b", e.parallel, rsp_if.parallel); errors++;
        end
        if (rsp_if.saturated !== e.saturated) begin
          $error("saturated exp %0b got %0b", e.saturated, rsp_if.saturated); errors++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rx_cyc++;
      if (rx_cyc % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= $urandom_range(0, 1);
        2: rsp_if.ready <= (rx_cyc % 5) < 2;
        default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("tb_line_plane_intersection: errors");
      $finish;
    end
  end

  task automatic send_req(logic typ, int sx, int sy, int sz, int dx, int dy, int dz);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 30);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        if (req_if.valid) req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    if (!req_if.valid) @(posedge clk);
    req_if.valid <= 1'b1;
    req_if.req_type <= typ;
    req_if.start_x <= coord_t'(sx);
    req_if.start_y <= coord_t'(sy);
    req_if.start_z <= coord_t'(sz);
    req_if.dir_x <= coord_t'(dx);
    req_if.dir_y <= coord_t'(dy);
    req_if.dir_z <= coord_t'(dz);
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic stop_sending();
    if (req_if.valid) req_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic drain();
    stop_sending();
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CW3-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_A: plane_a = val;
      REG_B: plane_b = val;
      REG_C: plane_c = val;
      default: ;
    endcase
  endtask

  task automatic set_plane(logic [CW3-1:0] pa, logic [CW3-1:0] pb, logic [CW3-1:0] pc);
    drain();
    write_reg(REG_A, pa);
    write_reg(REG_B, pb);
    write_reg(REG_C, pc);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 2 ** CB - 1) - 2 ** (CB - 1);
      1: return int'($urandom_range(0, 4095)) - 2048;
      2: return $urandom_range(0, 1) ? CMAX : CMIN;
      3: return int'($urandom_range(0, 15)) - 8;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic logic [CW3-1:0] rand_point();
    return pack_pt(rand_coord(), rand_coord(), rand_coord());
  endfunction

  task automatic test_flat_plane();
    set_plane(pack_pt(0, 0, 0), pack_pt(256, 0, 0), pack_pt(0, 256, 0));
    send_req(0, 0, 0, 256, 0, 0, -256);
    send_req(0, 100, -200, 512, 3, 7, 256);
    send_req(0, 0, 0, 256, 256, 0, 0);             // parallel
    send_req(0, 5, 6, 7, 0, 0, 0);                 // zero direction
    send_req(1, 300, -400, 999, CMIN, CMIN, CMIN); // direction ignored
    send_req(0, 0, 0, 1, 1, 0, 2);                 // rounding tie
    send_req(0, 0, 0, 1, -1, 0, 2);
    send_req(0, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    send_req(0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send_req(0, 0, 0, 1, CMAX, CMIN, 1);           // saturates
    send_req(0, 0, 0, CMAX, CMAX, CMAX, 1);        // huge offset
    send_req(1, CMIN, CMAX, CMIN, 0, 0, 0);
    send_req(0, -1, -1, -1, -1, -1, -1);
  endtask

  task automatic test_degenerate_plane();
    set_plane(pack_pt(10, 10, 10), pack_pt(20, 20, 20), pack_pt(40, 40, 40));
    send_req(0, 1, 2, 3, 4, 5, 6);
    send_req(1, CMAX, CMIN, 0, 0, 0, 0);
    drain();
    write_reg(REG_NONE, {CW3{1'b1}});
    set_plane({CW3{1'b1}}, {CW3{1'b1}}, {CW3{1'b1}});
    send_req(0, 7, 8, 9, 1, 1, 1);
  endtask

  task automatic test_extreme_plane();
    set_plane(pack_pt(CMIN, CMIN, CMIN), pack_pt(CMAX, CMIN, CMAX),
              pack_pt(CMIN, CMAX, CMAX));
    send_req(1, 0, 0, 0, 0, 0, 0);
    send_req(1, CMAX, CMAX, CMAX, 0, 0, 0);
    send_req(0, CMIN, CMAX, 0, CMAX, CMIN, CMAX);
    send_req(0, 1, -1, 1, 1, 1, 1);
    set_plane(pack_pt(CMAX, CMAX, CMAX), {CW3{1'b0}}, pack_pt(CMIN, 0, CMAX));
    send_req(0, 256, 512, -768, 1, 2, 3);
    send_req(1, -256, 0, 256, 0, 0, 0);
  endtask

  task automatic test_random_items(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 2) == 0)
        send_req(1, rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord());
      else
        send_req(0, rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  task automatic test_random_planes();
    for (int p = 0; p < 5; p++) begin
      if (p == 0)
        set_plane(pack_pt(0, 0, 512), pack_pt(1024, 0, 256), pack_pt(0, 768, 0));
      else
        set_plane(rand_point(), rand_point(), rand_point());
      test_random_items(260);
      if (p == 2) drain();  // full pause mid-run
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_A;
    cfg_data = '0;
    plane_a = '0;
    plane_b = '0;
    plane_c = '0;
    req_if.valid = 1'b0;
    req_if.req_type = 1'b0;
    req_if.start_x = '0;
    req_if.start_y = '0;
    req_if.start_z = '0;
    req_if.dir_x = '0;
    req_if.dir_y = '0;
    req_if.dir_z = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_req(0, 10, 20, 30, 1, 2, 3);  // plane at reset is degenerate
    test_flat_plane();
    test_degenerate_plane();
    test_extreme_plane();
    test_random_planes();
    drain();
    if (expected_hits.size() != 0) errors++;
    $display("covered %0d requests over 10 plane settings, both request types", n_req);
    $display("results %0d: %0d parallel, %0d clamped", n_rsp, n_par, n_sat);
    if (errors == 0)
      $display("tb_line_plane_intersection: clean");
    else
      $display("tb_line_plane_intersection: errors");
    $finish;
  end
endmodule

// File: sim.f
+incdir+design
design/lpi_pkg.sv
design/lpi_if.sv
design/lpi_div_stage.sv
design/line_plane_intersection.sv
dv/tb_line_plane_intersection.sv
